/* hw/rtl/assert_macros.svh */
// Assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, ignored while reset is held
`define MI3_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion, also checked during reset
`define MI3_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/mi3_pkg.sv */
// Shared constants and types for the 3x3 matrix inverse
package mi3_pkg;

  localparam int unsigned ELEMENT_WIDTH_DEF = 24;
  localparam int unsigned FRACTION_BITS_DEF = 16;
  localparam int unsigned N_ELEM            = 9;
  localparam int unsigned THR_WIDTH         = 32;
  localparam logic [THR_WIDTH-1:0] THR_RESET = 32'd42950;

  // adj[k] = a[i1]*a[j1] - a[i2]*a[j2], sign of the cofactor folded in
  localparam int unsigned COF_IDX [N_ELEM][4] = '{
    '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
    '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
    '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
  };

  // adjugate entries paired with a11, a12, a13 for the determinant
  localparam int unsigned DET_ROW [3] = '{0, 3, 6};

  typedef struct packed {
    logic neg;
    logic singular;
  } det_flags_t;

endpackage

/* hw/rtl/mi3_cof.sv */
// Cofactor products and adjugate, two pipeline stages
module mi3_cof import mi3_pkg::*; #(
  parameter int unsigned W = ELEMENT_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [W-1:0] a_i   [N_ELEM],
  output logic signed [2*W:0] adj_o [N_ELEM],
  output logic signed [W-1:0] a_o   [N_ELEM]
);

  logic signed [2*W-1:0] p1_r [N_ELEM];
  logic signed [2*W-1:0] p2_r [N_ELEM];
  logic signed [W-1:0]   a1_r [N_ELEM];
  logic signed [W-1:0]   a2_r [N_ELEM];
  logic signed [2*W:0]   adj_r [N_ELEM];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < N_ELEM; k++) begin
        p1_r[k]  <= a_i[COF_IDX[k][0]] * a_i[COF_IDX[k][1]];
        p2_r[k]  <= a_i[COF_IDX[k][2]] * a_i[COF_IDX[k][3]];
        a1_r[k]  <= a_i[k];
        adj_r[k] <= (2*W+1)'(p1_r[k]) - (2*W+1)'(p2_r[k]);
        a2_r[k]  <= a1_r[k];
      end
    end
  end

  assign adj_o = adj_r;
  assign a_o   = a2_r;

endmodule

/* hw/rtl/mi3_det.sv */
// Determinant, its magnitude and the singular test, three pipeline stages
module mi3_det import mi3_pkg::*; #(
  parameter int unsigned W = ELEMENT_WIDTH_DEF,
  parameter int unsigned F = FRACTION_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [THR_WIDTH-1:0] thr,
  input  logic signed [W-1:0]  a_i   [N_ELEM],
  input  logic signed [2*W:0]  adj_i [N_ELEM],
  output logic [3*W+2:0]       mag_o,
  output det_flags_t           flg_o
);

  localparam int unsigned AW = 2*W + 1;
  localparam int unsigned LO = W + 1;
  localparam int unsigned HI = AW - LO;
  localparam int unsigned DW = 3*W + 3;
  localparam int unsigned CW = DW + THR_WIDTH + 3*F;

  logic signed [W+LO:0]   plo_r [3];
  logic signed [W+HI-1:0] phi_r [3];
  logic signed [DW-1:0]   det_r;
  logic [DW-1:0]          mag_c;
  logic [CW-1:0]          lhs_c;
  logic [CW-1:0]          rhs_c;
  logic [DW-1:0]          mag_r;
  det_flags_t             flg_r;

  always_comb begin
    mag_c = det_r[DW-1] ? DW'(-det_r) : DW'(det_r);
    lhs_c = CW'(mag_c) << THR_WIDTH;
    rhs_c = CW'(thr) << (3*F);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        plo_r[j] <= a_i[j] * $signed({1'b0, adj_i[DET_ROW[j]][LO-1:0]});
        phi_r[j] <= a_i[j] * $signed(adj_i[DET_ROW[j]][AW-1:LO]);
      end
      det_r <= (DW'(phi_r[0]) <<< LO) + DW'(plo_r[0])
             + (DW'(phi_r[1]) <<< LO) + DW'(plo_r[1])
             + (DW'(phi_r[2]) <<< LO) + DW'(plo_r[2]);
      mag_r          <= mag_c;
      flg_r.neg      <= det_r[DW-1];
      flg_r.singular <= (mag_c == '0) || (lhs_c < rhs_c);
    end
  end

  assign mag_o = mag_r;
  assign flg_o = flg_r;

endmodule

/* hw/rtl/mi3_lane.sv */
// One element lane: pipelined restoring division with saturation
module mi3_lane import mi3_pkg::*; #(
  parameter int unsigned W = ELEMENT_WIDTH_DEF,
  parameter int unsigned F = FRACTION_BITS_DEF
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [2*W:0] adj_i,
  input  logic [W-1:0]        a_i,
  input  logic [3*W+2:0]      mag_i,
  input  det_flags_t          flg_i,
  input  logic [3*W+2:0]      d_i [W],
  output logic [W-1:0]        res_o,
  output logic                sat_o,
  output logic [W-1:0]        a_o
);

  localparam int unsigned AW = 2*W + 1;
  localparam int unsigned DW = 3*W + 3;
  localparam int unsigned NW = AW + 2*F;
  localparam int unsigned CW = (NW > DW + W) ? NW : DW + W;

  logic signed [AW-1:0] adj_d_r [3];
  logic [W-1:0]         a_d_r   [3];

  logic [DW-1:0] r_r   [W+1];
  logic [W-1:0]  q_r   [W+1];
  logic [W-1:0]  nl_r  [W+1];
  logic [W-1:0]  ae_r  [W+1];
  logic [W:0]    neg_r;
  logic [W:0]    ovf_r;

  logic [AW-1:0] m_c;
  logic [NW-1:0] n_c;
  logic          ovf_c;

  logic [W-1:0]  lim_c;
  logic          over_c;
  logic [W-1:0]  mq_c;
  logic [W-1:0]  res_r;
  logic          sat_r;
  logic [W-1:0]  aout_r;

  always_comb begin
    m_c   = adj_d_r[2][AW-1] ? AW'(-adj_d_r[2]) : AW'(adj_d_r[2]);
    n_c   = NW'(m_c) << (2*F);
    ovf_c = CW'(n_c) >= (CW'(mag_i) << W);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      adj_d_r[0] <= adj_i;
      adj_d_r[1] <= adj_d_r[0];
      adj_d_r[2] <= adj_d_r[1];
      a_d_r[0]   <= a_i;
      a_d_r[1]   <= a_d_r[0];
      a_d_r[2]   <= a_d_r[1];
      r_r[0]     <= DW'(n_c >> W);
      q_r[0]     <= '0;
      nl_r[0]    <= n_c[W-1:0];
      ae_r[0]    <= a_d_r[2];
      neg_r[0]   <= adj_d_r[2][AW-1] ^ flg_i.neg;
      ovf_r[0]   <= ovf_c;
    end
  end

  for (genvar j = 0; j < W; j++) begin : g_step
    logic [DW:0] t_c;
    logic        ge_c;

    always_comb begin
      t_c  = {r_r[j], nl_r[j][W-1]};
      ge_c = t_c >= {1'b0, d_i[j]};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_r[j+1]   <= ge_c ? DW'(t_c - {1'b0, d_i[j]}) : t_c[DW-1:0];
        q_r[j+1]   <= {q_r[j][W-2:0], ge_c};
        nl_r[j+1]  <= nl_r[j] << 1;
        ae_r[j+1]  <= ae_r[j];
        neg_r[j+1] <= neg_r[j];
        ovf_r[j+1] <= ovf_r[j];
      end
    end
  end

  always_comb begin
    lim_c  = neg_r[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    over_c = ovf_r[W] || (q_r[W] > lim_c);
    mq_c   = over_c ? lim_c : q_r[W];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r  <= neg_r[W] ? W'(-mq_c) : mq_c;
      sat_r  <= over_c;
      aout_r <= ae_r[W];
    end
  end

  assign res_o = res_r;
  assign sat_o = sat_r;
  assign a_o   = aout_r;

endmodule

/* hw/rtl/matrix_inverse_3x3.sv */
// Top level of the 3x3 matrix inverse
// Usage:
//   in_*  : one 3x3 matrix per item, nine signed elements packed in in_tdata.
//   out_* : the inverse in out_tdata, flags singular and saturated in out_tuser.
//   cfg_* : writes the singular threshold (units of 2^-32); always ready.
//           Write it only while no item is in flight.
// Throughput: one item per cycle while in_tready is high. Nine lanes
//   divide side by side, each a restoring divider unrolled into
//   ELEMENT_WIDTH one-bit stages.
// Pipeline: the input register takes the item as it is accepted, then
//   two cofactor stages, three determinant stages, division setup,
//   ELEMENT_WIDTH quotient bits, saturation and the output register.
// Stall: a skid register behind the output keeps in_tready high while one
//   result waits; once both hold results the whole pipeline holds and
//   in_tready drops until out_tready returns.
// Reset: synchronous rst_n empties the pipeline and output, and loads the
//   threshold with 42950 (about 1e-5).
module matrix_inverse_3x3 import mi3_pkg::*; #(
  parameter int unsigned ELEMENT_WIDTH = ELEMENT_WIDTH_DEF,
  parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // a11, a12, a13, a21, a22, a23, a31, a32, a33 from bit 0 up
  input  logic [((N_ELEM*ELEMENT_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // r11, r12, r13, r21, r22, r23, r31, r32, r33 from bit 0 up
  output logic [((N_ELEM*ELEMENT_WIDTH+7)/8)*8-1:0] out_tdata,
  // singular, saturated from bit 0 up
  output logic [1:0]                 out_tuser,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [THR_WIDTH-1:0]       cfg_data
);

  localparam int unsigned W   = ELEMENT_WIDTH;
  localparam int unsigned DW  = 3*W + 3;
  localparam int unsigned TDW = ((N_ELEM*W + 7) / 8) * 8;
  localparam int unsigned NS  = W + 8;

  logic                 en;
  logic [NS-1:0]        v_r;
  logic [THR_WIDTH-1:0] thr_r;

  logic signed [W-1:0]   a_r   [N_ELEM];
  logic signed [2*W:0]   adj2  [N_ELEM];
  logic signed [W-1:0]   a2    [N_ELEM];
  logic [DW-1:0]         mag5;
  det_flags_t            flg5;
  logic [DW-1:0]         d_r   [W];
  logic [W+1:0]          sg_r;

  logic [W-1:0]          res_w [N_ELEM];
  logic [W-1:0]          ae_w  [N_ELEM];
  logic [N_ELEM-1:0]     sat_w;

  logic [TDW-1:0]        m_data;
  logic [1:0]            m_user;
  logic                  v_in;

  logic                  out_v_r;
  logic [TDW-1:0]        out_d_r;
  logic [1:0]            out_u_r;
  logic                  skid_v_r;
  logic [TDW-1:0]        skid_d_r;
  logic [1:0]            skid_u_r;

  assign en        = !skid_v_r;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_valid) begin
      thr_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NS-2:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < N_ELEM; k++) begin
        a_r[k] <= in_tdata[k*W +: W];
      end
      d_r[0]  <= mag5;
      for (int j = 1; j < W; j++) begin
        d_r[j] <= d_r[j-1];
      end
      sg_r <= {sg_r[W:0], flg5.singular};
    end
  end

  mi3_cof #(.W(W)) u_cof (
    .clk   (clk),
    .en    (en),
    .a_i   (a_r),
    .adj_o (adj2),
    .a_o   (a2)
  );

  mi3_det #(.W(W), .F(FRACTION_BITS)) u_det (
    .clk   (clk),
    .en    (en),
    .thr   (thr_r),
    .a_i   (a2),
    .adj_i (adj2),
    .mag_o (mag5),
    .flg_o (flg5)
  );

  for (genvar k = 0; k < N_ELEM; k++) begin : g_lane
    mi3_lane #(.W(W), .F(FRACTION_BITS)) u_lane (
      .clk   (clk),
      .en    (en),
      .adj_i (adj2[k]),
      .a_i   (a2[k]),
      .mag_i (mag5),
      .flg_i (flg5),
      .d_i   (d_r),
      .res_o (res_w[k]),
      .sat_o (sat_w[k]),
      .a_o   (ae_w[k])
    );
  end

  always_comb begin
    m_data = '0;
    for (int k = 0; k < N_ELEM; k++) begin
      m_data[k*W +: W] = sg_r[W+1] ? ae_w[k] : res_w[k];
    end
    m_user = {(|sat_w) & !sg_r[W+1], sg_r[W+1]};
    v_in   = en & v_r[NS-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_tready || !out_v_r) begin
      out_v_r  <= skid_v_r | v_in;
      skid_v_r <= 1'b0;
    end else if (v_in) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_tready || !out_v_r) begin
      out_d_r <= skid_v_r ? skid_d_r : m_data;
      out_u_r <= skid_v_r ? skid_u_r : m_user;
    end else if (v_in) begin
      skid_d_r <= m_data;
      skid_u_r <= m_user;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;
  assign out_tuser  = out_u_r;

endmodule

/* hw/rtl/mi3_chk.sv */
// Port-level checker for the 3x3 matrix inverse, bound to the top level
`include "assert_macros.svh"

module mi3_chk #(
  parameter int unsigned TDW = 216
) (
  input logic           clk,
  input logic           rst_n,
  input logic           in_tready,
  input logic           out_tvalid,
  input logic           out_tready,
  input logic [TDW-1:0] out_tdata,
  input logic [1:0]     out_tuser
);

  `MI3_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled output item changed")
  `MI3_ASSERT(a_flag_excl, out_tvalid |-> !(out_tuser[0] && out_tuser[1]), "singular item flagged saturated")
  `MI3_ASSERT(a_ready_stall, !in_tready |-> $past(out_tvalid && !out_tready), "input blocked without output stall")
  `MI3_ASSERT_RST(a_reset_empty, !rst_n |=> !out_tvalid, "output valid right after reset")

endmodule

bind matrix_inverse_3x3 mi3_chk #(.TDW(TDW)) u_mi3_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
